/* hdl/kpbs_pkg.sv */
// shared types and constants of the kerning pair search unit
`timescale 1ns / 1ps
`default_nettype none

package kpbs_pkg;

    // field widths of the words on the ports
    localparam int GLYPH_W  = 16;
    localparam int KERN_W   = 16;
    localparam int KEY_W    = 2 * GLYPH_W;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int ENTRY_W  = KEY_W + KERN_W;

    // default table size
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // request mode codes
    localparam logic MODE_STORE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic store;
        logic start;
        logic step;
        logic hit;
        logic miss;
    } kpbs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic open_now;
        logic open_next;
        logic hit;
    } kpbs_sts_t;

endpackage

`default_nettype wire

/* hdl/kpbs_ifs.sv */
// valid/ready channel interfaces of the kerning pair search unit
`timescale 1ns / 1ps
`default_nettype none

// request channel: store or lookup word
interface kpbs_req_if
    import kpbs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [SLOT_W-1:0]         entry_index;
    logic [GLYPH_W-1:0]        first_glyph;
    logic [GLYPH_W-1:0]        second_glyph;
    logic signed [KERN_W-1:0]  kern_value;

    modport source (
        output valid, mode, entry_index, first_glyph, second_glyph, kern_value,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, first_glyph, second_glyph, kern_value,
        output ready
    );
endinterface

// response channel: one word per lookup
interface kpbs_rsp_if
    import kpbs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [KERN_W-1:0]  kern_x;
    logic                      found;

    modport source (
        output valid, kern_x, found,
        input  ready
    );
    modport sink (
        input  valid, kern_x, found,
        output ready
    );
endinterface

// configuration write channel: pair count
interface kpbs_cfg_if
    import kpbs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/kpbs_datapath.sv */
// table memory, search bounds, key compare and result register
`timescale 1ns / 1ps
`default_nettype none

module kpbs_datapath
    import kpbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [COUNT_W-1:0]        cfg_data,
    input  wire kpbs_cmd_t                 cmd,
    input  wire logic [SLOT_W-1:0]         entry_index,
    input  wire logic [GLYPH_W-1:0]        first_glyph,
    input  wire logic [GLYPH_W-1:0]        second_glyph,
    input  wire logic signed [KERN_W-1:0]  kern_value,
    output kpbs_sts_t                      sts,
    output logic signed [KERN_W-1:0]       kern_x,
    output logic                           found
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic [ENTRY_W-1:0]        kern_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]        rd_entry_reg;
    logic [COUNT_W-1:0]        num_pairs_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [CNT_W-1:0]          lo_reg;
    logic [CNT_W-1:0]          hi_reg;
    logic [CNT_W-1:0]          mid_reg;
    logic signed [KERN_W-1:0]  kern_x_reg;
    logic                      found_reg;

    logic [KEY_W-1:0]          key_in;
    logic [SLOT_EXT_W-1:0]     slot_ext;
    logic                      slot_ok;
    logic [CNT_W-1:0]          count_sat;
    logic [KEY_W-1:0]          rd_key;
    logic signed [KERN_W-1:0]  rd_val;
    logic                      rd_lt;
    logic [CNT_W-1:0]          lo_step;
    logic [CNT_W-1:0]          hi_step;
    logic [CNT_W-1:0]          lo_sel;
    logic [CNT_W-1:0]          hi_sel;
    logic [CNT_W:0]            mid_sum;
    logic [CNT_W-1:0]          mid_next;

    // key of the incoming word and store slot check
    assign key_in   = {first_glyph, second_glyph};
    assign slot_ext = SLOT_EXT_W'(entry_index);
    assign slot_ok  = 32'(entry_index) < 32'(TABLE_DEPTH);

    // pair count saturated to the table size
    assign count_sat = (32'(num_pairs_reg) > 32'(TABLE_DEPTH))
                     ? CNT_W'(TABLE_DEPTH) : CNT_W'(num_pairs_reg);

    // probed entry and its order against the search key
    assign rd_key = rd_entry_reg[ENTRY_W-1:KERN_W];
    assign rd_val = rd_entry_reg[KERN_W-1:0];
    assign rd_lt  = rd_key < key_reg;

    // bounds after the probe: lower bound inclusive, upper bound exclusive
    assign lo_step = rd_lt ? (mid_reg + CNT_W'(1)) : lo_reg;
    assign hi_step = rd_lt ? hi_reg : mid_reg;
    assign lo_sel  = cmd.step ? lo_step : lo_reg;
    assign hi_sel  = cmd.step ? hi_step : hi_reg;

    // midpoint of the bounds that hold next
    assign mid_sum  = {1'b0, lo_sel} + {1'b0, hi_sel} - (CNT_W + 1)'(1);
    assign mid_next = mid_sum[CNT_W:1];

    // status to the controller
    assign sts.open_now  = lo_reg < hi_reg;
    assign sts.open_next = lo_step < hi_step;
    assign sts.hit       = rd_key == key_reg;

    // table memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store && slot_ok)
        begin
            kern_mem[slot_ext[IDX_W-1:0]] <= {key_in, kern_value};
        end
        rd_entry_reg <= kern_mem[mid_next[IDX_W-1:0]];
    end

    // pair count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pairs_reg <= '0;
        end
        else if (cfg_we)
        begin
            num_pairs_reg <= cfg_data;
        end
    end

    // search key, bounds and last probe address
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key_in;
            lo_reg  <= '0;
            hi_reg  <= count_sat;
        end
        else if (cmd.step)
        begin
            lo_reg <= lo_step;
            hi_reg <= hi_step;
        end
        mid_reg <= mid_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.hit)
        begin
            kern_x_reg <= rd_val;
            found_reg  <= 1'b1;
        end
        else if (cmd.miss)
        begin
            kern_x_reg <= '0;
            found_reg  <= 1'b0;
        end
    end

    assign kern_x = kern_x_reg;
    assign found  = found_reg;

endmodule

`default_nettype wire

/* hdl/kpbs_ctrl.sv */
// search controller: sequences store, probe and result steps
`timescale 1ns / 1ps
`default_nettype none

module kpbs_ctrl
    import kpbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_mode,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire kpbs_sts_t  sts,
    output kpbs_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    // take a word only when idle and the result slot is free or draining
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_STORE)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                if (sts.open_now)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (sts.hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (!sts.open_next)
                    begin
                        cmd.miss   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.hit || cmd.miss)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/kerning_pair_binary_search_unit.sv */
// kerning pair table with binary search lookup, top level
// store word: written when taken if its slot lies in the table, no result word
// lookup word: a start step, then one probe a cycle (one registered table read each),
//   up to floor(log2(n))+1 probes over n pairs; no word is taken during a search, and
//   the next one can be taken in the same cycle as the result word if the receiver takes it
// reset clears the pair count and control state; table contents are kept
`timescale 1ns / 1ps
`default_nettype none

module kerning_pair_binary_search_unit
    import kpbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kpbs_req_if.sink   req,
    kpbs_rsp_if.source rsp,
    kpbs_cfg_if.sink   cfg
);

    kpbs_cmd_t cmd;
    kpbs_sts_t sts;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    // controller
    kpbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    kpbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.data),
        .cmd          (cmd),
        .entry_index  (req.entry_index),
        .first_glyph  (req.first_glyph),
        .second_glyph (req.second_glyph),
        .kern_value   (req.kern_value),
        .sts          (sts),
        .kern_x       (rsp.kern_x),
        .found        (rsp.found)
    );

    // a word is never taken while an unread result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !(rsp.valid && !rsp.ready))
        else $error("request taken while result word blocked");

    // a result only appears out of a search, never straight from idle
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> !$past(req.ready))
        else $error("result word raised while idle");

    // a miss carries zero adjustment
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.kern_x == '0))
        else $error("miss with nonzero adjustment");

    // a lookup closes the request side for the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.mode == MODE_LOOKUP)) |=> !req.ready)
        else $error("request side open during search");

endmodule

`default_nettype wire

/* bench/kern_lookup_checker.sv */
// channel monitor, pair table predictor and result checker for the kerning pair search unit
`timescale 1ns / 1ps

module kern_lookup_checker
    import kpbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    kpbs_req_if       req,
    kpbs_rsp_if       rsp,
    kpbs_cfg_if       cfg,
    output int        mismatch_count,
    output int        pending_words
);

    // one predicted lookup result
    typedef struct packed {
        logic signed [KERN_W-1:0] kern_x;
        logic                     found;
    } kern_word_t;

    // own copy of the pair table and the pair count
    logic [KEY_W-1:0]         pair_key  [TABLE_DEPTH];
    logic signed [KERN_W-1:0] pair_kern [TABLE_DEPTH];
    logic [COUNT_W-1:0]       pair_count;

    // results still owed by the block, oldest first
    kern_word_t expected_words [$];

    // binary search over the counted pairs, same probe order as the block
    function automatic kern_word_t search_pairs(input logic [KEY_W-1:0] key);
        kern_word_t w;
        int         lo;
        int         hi;
        int         mid;
        int         span;
        w.kern_x = '0;
        w.found  = 1'b0;
        span = (int'(pair_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(pair_count);
        lo = 0;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (pair_key[mid] == key)
            begin
                w.kern_x = pair_kern[mid];
                w.found  = 1'b1;
                break;
            end
            if (pair_key[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return w;
    endfunction

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        kern_word_t want;
        if (!rst_n)
        begin
            pair_count = '0;
            expected_words.delete();
            mismatch_count = 0;
            pending_words  = 0;
        end
        else
        begin
            // result words: compare with the oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, kern_x %0d found %0b",
                             $time, rsp.kern_x, rsp.found);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.kern_x !== want.kern_x)
                    begin
                        $display("%0t: kern_x mismatch, expected %0d, actual %0d",
                                 $time, want.kern_x, rsp.kern_x);
                        mismatch_count++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, rsp.found);
                        mismatch_count++;
                    end
                end
            end

            // pair count register write
            if (cfg.valid && cfg.ready)
                pair_count = cfg.data;

            // request words: stores update the table, lookups owe a result
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_STORE)
                begin
                    if (int'(req.entry_index) < TABLE_DEPTH)
                    begin
                        pair_key[req.entry_index]  = {req.first_glyph, req.second_glyph};
                        pair_kern[req.entry_index] = req.kern_value;
                    end
                end
                else
                    expected_words.push_back(
                        search_pairs({req.first_glyph, req.second_glyph}));
            end

            pending_words = expected_words.size();
        end
    end

endmodule

/* bench/kerning_pair_binary_search_unit_tb.sv */
// stimulus, stall patterns and verdict for the kerning pair search unit
`timescale 1ns / 1ps

module kerning_pair_binary_search_unit_tb;

    import kpbs_pkg::*;

    localparam int TABLE_DEPTH      = DEFAULT_TABLE_DEPTH;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 20;
    localparam int DRAIN_CYCLES     = 30;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASES           = 12;
    localparam int HOLD_PHASE       = 2;
    localparam int SCRAMBLE_PHASE   = 11;

    // receiver stall patterns
    typedef enum int {
        RSP_ALWAYS,
        RSP_HALF,
        RSP_SPARSE,
        RSP_PERIODIC
    } rsp_pattern_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   mismatch_count;
    int   pending_words;
    int   burst_left = 0;
    int   idle_cycles = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    // keys as stored, used to aim lookups at present pairs and to keep rewrites sorted
    logic [KEY_W-1:0] slot_key [TABLE_DEPTH];

    kpbs_req_if req_ch ();
    kpbs_rsp_if rsp_ch ();
    kpbs_cfg_if cfg_ch ();

    kerning_pair_binary_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    kern_lookup_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) lookup_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one request word, then keep the burst going or leave a gap
    task automatic send_word(input logic mode, input logic [SLOT_W-1:0] slot,
                             input logic [GLYPH_W-1:0] left, input logic [GLYPH_W-1:0] right,
                             input logic signed [KERN_W-1:0] kern);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.entry_index  <= slot;
        req_ch.first_glyph  <= left;
        req_ch.second_glyph <= right;
        req_ch.kern_value   <= kern;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 25) : $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic store_pair(input int slot, input logic [KEY_W-1:0] key,
                              input logic signed [KERN_W-1:0] kern);
        slot_key[slot] = key;
        send_word(MODE_STORE, slot[SLOT_W-1:0], key[KEY_W-1:GLYPH_W], key[GLYPH_W-1:0], kern);
    endtask

    // lookup word with random filler in the fields it ignores
    task automatic lookup_pair(input logic [KEY_W-1:0] key);
        send_word(MODE_LOOKUP, SLOT_W'($urandom), key[KEY_W-1:GLYPH_W], key[GLYPH_W-1:0],
                  KERN_W'($urandom));
    endtask

    // stop offering, let every owed result arrive, then let the block settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pair_count(input int count);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= count[COUNT_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // whole table in ascending key order, key 0 first and all ones last, some repeats
    task automatic fill_sorted_table();
        logic [KEY_W:0]           acc;
        logic signed [KERN_W-1:0] kern;
        acc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                acc = {1'b0, {KEY_W{1'b1}}};
            else if (i > 0)
            begin
                if ($urandom_range(0, 15) != 0)
                    acc = acc + $urandom_range(1, 7000000);
                if (acc > {1'b0, {(KEY_W-1){1'b1}}, 1'b0})
                    acc = {1'b0, {(KEY_W-1){1'b1}}, 1'b0};
            end
            if (i == 0)
                kern = 16'sh8000;
            else if (i == TABLE_DEPTH - 1)
                kern = 16'sh7FFF;
            else
                kern = KERN_W'($urandom);
            store_pair(i, acc[KEY_W-1:0], kern);
        end
    endtask

    // rewrite one slot with a key that keeps the table sorted
    task automatic store_sorted_random();
        int               slot;
        logic [KEY_W-1:0] lo_key;
        logic [KEY_W-1:0] hi_key;
        slot   = $urandom_range(0, TABLE_DEPTH - 1);
        lo_key = (slot == 0) ? '0 : slot_key[slot-1];
        hi_key = (slot == TABLE_DEPTH - 1) ? '1 : slot_key[slot+1];
        store_pair(slot, lo_key + $urandom_range(0, hi_key - lo_key), KERN_W'($urandom));
    endtask

    // mostly keys that are present, the rest near misses, random keys and extremes
    task automatic lookup_random(input int span);
        int               pick;
        int               slot;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 9);
        slot = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (span == 0 || pick == 8)
            key = $urandom;
        else if (pick <= 5)
            key = slot_key[slot];
        else if (pick == 6)
            key = slot_key[slot] + 1'b1;
        else if (pick == 7)
            key = slot_key[slot] - 1'b1;
        else
            key = ($urandom_range(0, 1) == 1) ? '1 : '0;
        lookup_pair(key);
    endtask

    // receiver ready: changing stall patterns, one long hold on request
    initial
    begin : rsp_stall_gen
        rsp_pattern_t pattern;
        int           pattern_left;
        int           tick;
        rsp_ch.ready <= 1'b0;
        pattern      = RSP_ALWAYS;
        pattern_left = 0;
        tick         = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (pattern_left == 0)
            begin
                pattern      = rsp_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(8, 80);
            end
            pattern_left--;
            tick++;
            case (pattern)
                RSP_ALWAYS: rsp_ch.ready <= 1'b1;
                RSP_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                RSP_SPARSE: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                default:    rsp_ch.ready <= ((tick % 4) < 2);
            endcase
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int fixed_counts [8];
        int count;
        int span;
        int pick;
        fixed_counts = '{2, 3, TABLE_DEPTH, 2047, 1023, 7, 0, 1025};
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_STORE;
        req_ch.entry_index  <= '0;
        req_ch.first_glyph  <= '0;
        req_ch.second_glyph <= '0;
        req_ch.kern_value   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: extreme pairs and ignored fields, all miss
        send_word(MODE_LOOKUP, '1, '1, '1, 16'sh7FFF);
        send_word(MODE_LOOKUP, '0, '0, '0, 16'sh8000);
        send_word(MODE_LOOKUP, '0, '1, '0, 16'sh0000);
        fill_sorted_table();
        // table filled but count still zero
        lookup_pair(slot_key[0]);

        // single pair
        set_pair_count(1);
        lookup_pair('0);
        lookup_pair(32'h0000_0001);
        lookup_pair('1);

        // full table: both ends, the middle and a near miss
        set_pair_count(TABLE_DEPTH);
        lookup_pair('1);
        lookup_pair('0);
        lookup_pair(slot_key[TABLE_DEPTH/2 - 1]);
        lookup_pair(slot_key[TABLE_DEPTH/2 - 1] + 1'b1);
        // repeated key in neighbouring slots
        store_pair(2, slot_key[1], 16'sh1234);
        lookup_pair(slot_key[1]);

        // count above the table depth saturates
        set_pair_count(2047);
        lookup_pair('1);
        lookup_pair(slot_key[700]);
        set_pair_count(0);
        lookup_pair('0);

        // random phases over a range of pair counts, out-of-order keys last
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == SCRAMBLE_PHASE)
                count = TABLE_DEPTH;
            else if (phase < 8)
                count = fixed_counts[phase];
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    count = $urandom_range(1, 64);
                else if (pick < 8)
                    count = $urandom_range(65, TABLE_DEPTH);
                else
                    count = $urandom_range(TABLE_DEPTH + 1, 2047);
            end
            span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            set_pair_count(count);
            if (phase == HOLD_PHASE)
                hold_req <= 1'b1;
            // out-of-order keys: the search may miss present pairs
            if (phase == SCRAMBLE_PHASE)
                repeat (30) store_pair($urandom_range(0, TABLE_DEPTH - 1), $urandom,
                                       KERN_W'($urandom));
            else
                repeat ($urandom_range(0, 6)) store_sorted_random();
            repeat ($urandom_range(10, 24)) lookup_random(span);
        end

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
